>>> hdl/chtb_pkg.sv
package chtb_pkg;

    // Fixed field widths of the item and result words.
    localparam int KIND_W   = 2;
    localparam int LEN_W    = 5;
    localparam int COUNT_W  = 8;
    localparam int SYM_W    = 8;
    localparam int CODE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int SEEN_W   = 9;
    localparam int TOTAL_W  = 12;

    // Item kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_COUNT  = 2'd0,
        KIND_SYMBOL = 2'd1,
        KIND_LOOKUP = 2'd2
    } kind_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_MISMATCH = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SKIP
    } state_t;

    // Commands from the sequencer to the build datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic take;
    } build_cmd_t;

    // Build datapath status towards the sequencer.
    typedef struct packed {
        logic              full;
        logic              need_step;
        logic              empty;
        logic              match;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  size;
    } build_stat_t;

endpackage

>>> hdl/canonical_huffman_table_builder.sv
// Channel  Direction  Ports                                              Word
// s_       in         s_valid s_ready s_kind s_code_length s_code_count  one item
//                     s_symbol s_last
// m_       out        m_valid m_ready m_out_symbol m_code_bits           one result
//                     m_code_size m_status
//
// A count write, or a symbol beyond the counts, is handled in the idle state. A lookup
// goes through the store read and then the result register. A symbol that gets a
// code goes through the length walk and then the result register, as the walk moves
// on one code length a cycle whenever the current length has no codes left.
// Reset is synchronous; the store's valid bits clear at once, with no pass.
// The input is held off while a result waits unaccepted at the output.
module canonical_huffman_table_builder #(
    parameter int MAX_CODE_LENGTH = 16,
    parameter int SYMBOL_COUNT    = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [chtb_pkg::KIND_W-1:0]   s_kind,
    input  logic [chtb_pkg::LEN_W-1:0]    s_code_length,
    input  logic [chtb_pkg::COUNT_W-1:0]  s_code_count,
    input  logic [chtb_pkg::SYM_W-1:0]    s_symbol,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [chtb_pkg::SYM_W-1:0]    m_out_symbol,
    output logic [chtb_pkg::CODE_W-1:0]   m_code_bits,
    output logic [chtb_pkg::LEN_W-1:0]    m_code_size,
    output logic [chtb_pkg::STATUS_W-1:0] m_status
);

    localparam int AW = $clog2(SYMBOL_COUNT);

    chtb_pkg::state_t             state_reg, state_next;
    chtb_pkg::build_cmd_t         cmd;
    chtb_pkg::build_stat_t        stat;
    logic [chtb_pkg::SYM_W-1:0]   sym_reg, sym_next;
    logic                         last_reg, last_next;
    logic                         range_reg, range_next;
    logic                         in_range;
    logic                         accept;
    logic                         rd_en, wr_en;
    logic [chtb_pkg::CODE_W-1:0]  rd_code;
    logic [chtb_pkg::LEN_W-1:0]   rd_size;
    logic                         m_valid_reg, m_valid_next;
    logic [chtb_pkg::SYM_W-1:0]   m_sym_reg, m_sym_next;
    logic [chtb_pkg::CODE_W-1:0]  m_code_reg, m_code_next;
    logic [chtb_pkg::LEN_W-1:0]   m_size_reg, m_size_next;
    chtb_pkg::status_t            m_status_reg, m_status_next;

    assign s_ready  = (state_reg == chtb_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign in_range = ({1'b0, s_symbol} < (chtb_pkg::SYM_W+1)'(SYMBOL_COUNT));

    chtb_build #(
        .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
    ) u_build (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .load_len (s_code_length),
        .load_cnt (s_code_count),
        .stat     (stat)
    );

    chtb_store #(
        .SYMBOL_COUNT(SYMBOL_COUNT)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (s_symbol[AW-1:0]),
        .rd_code (rd_code),
        .rd_size (rd_size),
        .wr_en   (wr_en),
        .wr_addr (sym_reg[AW-1:0]),
        .wr_code (stat.code),
        .wr_size (stat.size)
    );

    // Sequencer: next state, build commands, store access and result word.
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        sym_next      = sym_reg;
        last_next     = last_reg;
        range_next    = range_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_sym_next    = m_sym_reg;
        m_code_next   = m_code_reg;
        m_size_next   = m_size_reg;
        m_status_next = m_status_reg;
        unique case (state_reg)
            chtb_pkg::ST_IDLE: begin
                if (accept) begin
                    sym_next   = s_symbol;
                    last_next  = s_last;
                    range_next = in_range;
                    unique case (s_kind)
                        chtb_pkg::KIND_COUNT: begin
                            cmd.load = 1'b1;
                        end
                        chtb_pkg::KIND_SYMBOL: begin
                            if (stat.full) begin
                                m_valid_next  = 1'b1;
                                m_sym_next    = s_symbol;
                                m_code_next   = '0;
                                m_size_next   = '0;
                                m_status_next = chtb_pkg::STATUS_OVERFLOW;
                            end else begin
                                state_next = chtb_pkg::ST_SKIP;
                            end
                        end
                        chtb_pkg::KIND_LOOKUP: begin
                            rd_en      = 1'b1;
                            state_next = chtb_pkg::ST_LOOKUP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            chtb_pkg::ST_LOOKUP: begin
                m_valid_next  = 1'b1;
                m_sym_next    = sym_reg;
                m_size_next   = range_reg ? rd_size : '0;
                m_code_next   = (range_reg && (rd_size != '0)) ? rd_code : '0;
                m_status_next = chtb_pkg::STATUS_OK;
                state_next    = chtb_pkg::ST_IDLE;
            end
            chtb_pkg::ST_SKIP: begin
                if (stat.need_step) begin
                    cmd.step = 1'b1;
                end else if (stat.empty) begin
                    m_valid_next  = 1'b1;
                    m_sym_next    = sym_reg;
                    m_code_next   = '0;
                    m_size_next   = '0;
                    m_status_next = chtb_pkg::STATUS_OVERFLOW;
                    state_next    = chtb_pkg::ST_IDLE;
                end else begin
                    cmd.take      = 1'b1;
                    wr_en         = range_reg;
                    m_valid_next  = 1'b1;
                    m_sym_next    = sym_reg;
                    m_code_next   = stat.code;
                    m_size_next   = stat.size;
                    m_status_next = (last_reg && !stat.match) ?
                                    chtb_pkg::STATUS_MISMATCH : chtb_pkg::STATUS_OK;
                    state_next    = chtb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = chtb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= chtb_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Item and result word registers.
    always_ff @(posedge aclk) begin
        sym_reg      <= sym_next;
        last_reg     <= last_next;
        range_reg    <= range_next;
        m_sym_reg    <= m_sym_next;
        m_code_reg   <= m_code_next;
        m_size_reg   <= m_size_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_symbol = m_sym_reg;
    assign m_code_bits  = m_code_reg;
    assign m_code_size  = m_size_reg;
    assign m_status     = m_status_reg;

    // The store is written only when a symbol takes its code.
    a_write_in_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == chtb_pkg::ST_SKIP))
        else $error("store written outside the length walk");

    // A lookup word goes to the read state in the next cycle.
    a_lookup_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_kind == chtb_pkg::KIND_LOOKUP))
        |=> (state_reg == chtb_pkg::ST_LOOKUP))
        else $error("lookup word did not reach the read state");

    // While a word is in work the result register is free for it.
    a_output_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != chtb_pkg::ST_IDLE) |-> !m_valid_reg)
        else $error("result register busy while a word is in work");

    // No result carries a size beyond the longest code.
    a_size_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_code_size <= chtb_pkg::LEN_W'(MAX_CODE_LENGTH)))
        else $error("code size beyond the longest code length");

endmodule

>>> hdl/chtb_store.sv
module chtb_store #(
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            rd_en,
    input  logic [$clog2(SYMBOL_COUNT)-1:0] rd_addr,
    output logic [chtb_pkg::CODE_W-1:0]     rd_code,
    output logic [chtb_pkg::LEN_W-1:0]      rd_size,
    input  logic                            wr_en,
    input  logic [$clog2(SYMBOL_COUNT)-1:0] wr_addr,
    input  logic [chtb_pkg::CODE_W-1:0]     wr_code,
    input  logic [chtb_pkg::LEN_W-1:0]      wr_size
);

    localparam int DW = chtb_pkg::CODE_W + chtb_pkg::LEN_W;

    logic [DW-1:0]           mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] vld_reg;
    logic [DW-1:0]           rdata_reg;
    logic                    rvld_reg;

    // Code and size share one word; the read data is registered.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_code, wr_size};
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // One valid bit per entry so that an unwritten entry reads as size zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_code = rdata_reg[DW-1 -: chtb_pkg::CODE_W];
    assign rd_size = rvld_reg ? rdata_reg[chtb_pkg::LEN_W-1:0] : '0;

endmodule

>>> hdl/chtb_build.sv
module chtb_build #(
    parameter int MAX_CODE_LENGTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  chtb_pkg::build_cmd_t         cmd,
    input  logic [chtb_pkg::LEN_W-1:0]   load_len,
    input  logic [chtb_pkg::COUNT_W-1:0] load_cnt,
    output chtb_pkg::build_stat_t        stat
);

    localparam int LW = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;

    logic [chtb_pkg::COUNT_W-1:0] counts_reg [MAX_CODE_LENGTH];
    logic [chtb_pkg::LEN_W-1:0]   cur_reg, cur_next;
    logic [chtb_pkg::COUNT_W-1:0] left_reg, left_next;
    logic [chtb_pkg::CODE_W:0]    code_reg, code_next;
    logic [chtb_pkg::SEEN_W-1:0]  seen_reg, seen_next;
    logic [chtb_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [chtb_pkg::LEN_W-1:0]   len_m1;
    logic [LW-1:0]                load_idx;
    logic                         load_ok;
    logic [chtb_pkg::SEEN_W-1:0]  seen_inc;

    assign len_m1   = load_len - chtb_pkg::LEN_W'(1);
    assign load_idx = len_m1[LW-1:0];
    assign load_ok  = cmd.load && (load_len != '0)
                      && (load_len <= chtb_pkg::LEN_W'(MAX_CODE_LENGTH));
    assign seen_inc = seen_reg + chtb_pkg::SEEN_W'(1);

    // Next build state: a count write restarts, a step moves to the next
    // length, a take hands out the current code.
    always_comb begin
        cur_next   = cur_reg;
        left_next  = left_reg;
        code_next  = code_reg;
        seen_next  = seen_reg;
        total_next = total_reg;
        if (load_ok) begin
            total_next = total_reg - chtb_pkg::TOTAL_W'(counts_reg[load_idx])
                         + chtb_pkg::TOTAL_W'(load_cnt);
            cur_next   = '0;
            left_next  = '0;
            code_next  = '0;
            seen_next  = '0;
        end else if (cmd.step) begin
            cur_next  = cur_reg + chtb_pkg::LEN_W'(1);
            code_next = {code_reg[chtb_pkg::CODE_W-1:0], 1'b0};
            left_next = counts_reg[cur_reg[LW-1:0]];
        end else if (cmd.take) begin
            code_next = code_reg + (chtb_pkg::CODE_W+1)'(1);
            left_next = left_reg - chtb_pkg::COUNT_W'(1);
            seen_next = seen_inc;
        end
    end

    // Count table and build registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
                counts_reg[i] <= '0;
            end
            cur_reg   <= '0;
            left_reg  <= '0;
            code_reg  <= '0;
            seen_reg  <= '0;
            total_reg <= '0;
        end else begin
            if (load_ok) begin
                counts_reg[load_idx] <= load_cnt;
            end
            cur_reg   <= cur_next;
            left_reg  <= left_next;
            code_reg  <= code_next;
            seen_reg  <= seen_next;
            total_reg <= total_next;
        end
    end

    // Status towards the sequencer.
    always_comb begin
        stat.full      = (chtb_pkg::TOTAL_W'(seen_reg) >= total_reg)
                         || (seen_reg == '1);
        stat.empty     = (left_reg == '0);
        stat.need_step = (left_reg == '0)
                         && (cur_reg < chtb_pkg::LEN_W'(MAX_CODE_LENGTH));
        stat.match     = (chtb_pkg::TOTAL_W'(seen_inc) == total_reg);
        stat.code      = code_reg[chtb_pkg::CODE_W-1:0];
        stat.size      = cur_reg;
    end

endmodule

>>> sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import chtb_pkg::*;

    localparam int MAX_LEN        = 16;
    localparam int SYM_SPACE      = 256;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int MAX_TABLE_SYMS = 64;
    localparam int SATURATE_SYMS  = 515;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int REPORT_LIMIT   = 10;

    // The fourth kind has no meaning and must be ignored by the block.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [LEN_W-1:0]   len;
        logic [COUNT_W-1:0] count;
        logic [SYM_W-1:0]   sym;
        logic               last;
    } huff_item_t;

    typedef struct {
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  size;
        status_t           status;
    } huff_result_t;

    typedef struct {
        huff_item_t   it;
        bit           typed;
        huff_result_t want;
    } dir_row_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [KIND_W-1:0]     s_kind        = '0;
    logic [LEN_W-1:0]      s_code_length = '0;
    logic [COUNT_W-1:0]    s_code_count  = '0;
    logic [SYM_W-1:0]      s_symbol      = '0;
    logic                  s_last        = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [SYM_W-1:0]      m_out_symbol;
    logic [CODE_W-1:0]     m_code_bits;
    logic [LEN_W-1:0]      m_code_size;
    logic [STATUS_W-1:0]   m_status;

    // Predicted table state, reset to zero like the block.
    bit [COUNT_W-1:0] len_counts [MAX_LEN];
    bit [CODE_W-1:0]  code_mem [SYM_SPACE];
    bit [LEN_W-1:0]   size_mem [SYM_SPACE];
    bit [LEN_W-1:0]   cur_len;
    bit [COUNT_W-1:0] left_len;
    bit [CODE_W:0]    run_code;
    bit [SEEN_W-1:0]  seen_syms;
    bit [TOTAL_W-1:0] total_codes;

    huff_result_t expected_codes [$];
    huff_result_t head;
    int           fault_count   = 0;
    int           items_sent    = 0;
    int           idle_cycles   = 0;
    bit           quiet_phase   = 1'b0;
    bit           hold_off_req  = 1'b0;

    canonical_huffman_table_builder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_code_length (s_code_length),
        .s_code_count  (s_code_count),
        .s_symbol      (s_symbol),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_symbol  (m_out_symbol),
        .m_code_bits   (m_code_bits),
        .m_code_size   (m_code_size),
        .m_status      (m_status)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Predicts the result of one accepted word and advances the table state.
    function automatic bit predict_code(input huff_item_t it, output huff_result_t res);
        int unsigned sum;
        res.sym    = it.sym;
        res.code   = '0;
        res.size   = '0;
        res.status = STATUS_OK;
        case (it.kind)
            KIND_COUNT: begin
                if (it.len < 1 || it.len > MAX_LEN) return 1'b0;
                len_counts[4'(it.len - 5'd1)] = it.count;
                sum = 0;
                for (int k = 0; k < MAX_LEN; k++) sum += len_counts[k];
                total_codes = sum[TOTAL_W-1:0];
                cur_len   = '0;
                left_len  = '0;
                run_code  = '0;
                seen_syms = '0;
                return 1'b0;
            end
            KIND_SYMBOL: begin
                if ({3'b000, seen_syms} >= total_codes || seen_syms == 9'd511) begin
                    res.status = STATUS_OVERFLOW;
                    return 1'b1;
                end
                // Walk past empty lengths, doubling the running code each step.
                while (left_len == 0 && cur_len < MAX_LEN) begin
                    cur_len  = cur_len + 5'd1;
                    run_code = {run_code[CODE_W-1:0], 1'b0};
                    left_len = len_counts[4'(cur_len - 5'd1)];
                end
                if (left_len == 0) begin
                    res.status = STATUS_OVERFLOW;
                    return 1'b1;
                end
                res.code  = run_code[CODE_W-1:0];
                res.size  = cur_len;
                run_code  = run_code + 17'd1;
                left_len  = left_len - 8'd1;
                seen_syms = seen_syms + 9'd1;
                if (int'(it.sym) < SYM_SPACE) begin
                    code_mem[it.sym] = res.code;
                    size_mem[it.sym] = res.size;
                end
                if (it.last && {3'b000, seen_syms} != total_codes) res.status = STATUS_MISMATCH;
                return 1'b1;
            end
            KIND_LOOKUP: begin
                if (int'(it.sym) < SYM_SPACE) begin
                    res.size = size_mem[it.sym];
                    if (res.size != 0) res.code = code_mem[it.sym];
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (quiet_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic dir_row_t dir_row(input logic [KIND_W-1:0] kind, input int len,
                                         input int cnt, input int sym, input bit last,
                                         input bit typed, input int code, input int size,
                                         input status_t status);
        dir_row_t r;
        r.it.kind     = kind;
        r.it.len      = len[LEN_W-1:0];
        r.it.count    = cnt[COUNT_W-1:0];
        r.it.sym      = sym[SYM_W-1:0];
        r.it.last     = last;
        r.typed       = typed;
        r.want.sym    = sym[SYM_W-1:0];
        r.want.code   = code[CODE_W-1:0];
        r.want.size   = size[LEN_W-1:0];
        r.want.status = status;
        return r;
    endfunction

    // Offers one word after a random gap and records its expected result once taken.
    task automatic offer_word(input huff_item_t it, input bit typed, input huff_result_t want);
        huff_result_t pred;
        bit           has;
        int           gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_kind        <= it.kind;
        s_code_length <= it.len;
        s_code_count  <= it.count;
        s_symbol      <= it.sym;
        s_last        <= it.last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        has = predict_code(it, pred);
        if (has) begin
            if (typed) expected_codes.push_back(want);
            else expected_codes.push_back(pred);
        end
        if (!(it.kind == KIND_UNUSED ||
              (it.kind == KIND_COUNT && (it.len < 1 || it.len > MAX_LEN))))
            items_sent++;
    endtask

    // A word that does not belong to a well-formed build sequence.
    task automatic send_noise();
        huff_item_t   it;
        huff_result_t none;
        it.kind  = 2'($urandom_range(0, 3));
        it.len   = 5'($urandom_range(0, 31));
        it.count = 8'($urandom_range(0, 255));
        it.sym   = 8'($urandom_range(0, 255));
        it.last  = 1'($urandom_range(0, 1));
        if (it.kind == KIND_COUNT && it.len >= 1 && it.len <= MAX_LEN)
            it.len = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(MAX_LEN + 1, 31));
        offer_word(it, 1'b0, none);
    endtask

    // One table: all sixteen counts in random order, its symbols, then lookups.
    task automatic send_random_table(input bit saturate);
        huff_item_t   it;
        huff_result_t none;
        int           cnt_of [MAX_LEN];
        int           order [MAX_LEN];
        int           syms [$];
        int           avail, total, n, extra, last_pos, nlook, j, tmp;
        bit           noisy, broken;
        noisy       = saturate || ($urandom_range(0, 7) == 0);
        broken      = !saturate && ($urandom_range(0, 4) == 0);
        quiet_phase = ($urandom_range(0, 4) == 0);
        avail = 2;
        total = 0;
        // Well-formed counts stay within the prefix-code capacity.
        for (int k = 0; k < MAX_LEN; k++) begin
            if (saturate) cnt_of[k] = 255;
            else if (noisy) cnt_of[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0;
            else if ($urandom_range(0, 2) == 0)
                cnt_of[k] = $urandom_range(0, (avail < 3) ? avail : 3);
            else cnt_of[k] = 0;
            avail = (avail - cnt_of[k]) * 2;
            if (avail < 0) avail = 0;
            if (avail > 1024) avail = 1024;
            total += cnt_of[k];
            order[k] = k;
        end
        for (int k = MAX_LEN - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < MAX_LEN; k++) begin
            if ($urandom_range(0, 15) == 0) send_noise();
            it.kind  = KIND_COUNT;
            it.len   = 5'(order[k] + 1);
            it.count = 8'(cnt_of[order[k]]);
            it.sym   = 8'($urandom_range(0, 255));
            it.last  = 1'($urandom_range(0, 1));
            offer_word(it, 1'b0, none);
        end
        // Symbols in table order; a broken table misplaces the last mark or runs over.
        n        = saturate ? SATURATE_SYMS : ((total > MAX_TABLE_SYMS) ? MAX_TABLE_SYMS : total);
        extra    = broken ? $urandom_range(0, 3) : 0;
        last_pos = broken ? $urandom_range(0, n + extra) : n - 1;
        for (int k = 0; k < n + extra; k++) begin
            if ($urandom_range(0, 19) == 0) send_noise();
            it.kind  = KIND_SYMBOL;
            it.len   = 5'($urandom_range(0, 31));
            it.count = 8'($urandom_range(0, 255));
            it.sym   = 8'($urandom_range(0, 255));
            it.last  = (k == last_pos) || (broken && $urandom_range(0, 9) == 0);
            syms.push_back(int'(it.sym));
            offer_word(it, 1'b0, none);
        end
        // Lookups, mostly of symbols just given a code.
        nlook = $urandom_range(2, 12);
        for (int k = 0; k < nlook; k++) begin
            it.kind  = KIND_LOOKUP;
            it.len   = 5'($urandom_range(0, 31));
            it.count = 8'($urandom_range(0, 255));
            it.last  = 1'($urandom_range(0, 1));
            if (syms.size() > 0 && $urandom_range(0, 3) != 0)
                it.sym = 8'(syms[$urandom_range(0, syms.size() - 1)]);
            else
                it.sym = 8'($urandom_range(0, 255));
            offer_word(it, 1'b0, none);
        end
    endtask

    // Result side: random stalls, quiet stretches and one long hold-off on request.
    initial begin : result_sink
        int hold;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready      <= 1'b0;
                hold_off_req = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (quiet_phase) begin
                m_ready <= 1'b1;
            end else begin
                hold = pick_gap();
                if (hold == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (hold - 1) @(negedge aclk);
                end
            end
        end
    end

    // Each result word is compared with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_codes.size() == 0) begin
                if (fault_count < REPORT_LIMIT)
                    $display("%0t: unexpected result: sym %0d code %h size %0d status %0d",
                             $time, m_out_symbol, m_code_bits, m_code_size, m_status);
                fault_count++;
            end else begin
                head = expected_codes.pop_front();
                if (m_out_symbol !== head.sym || m_code_bits !== head.code ||
                    m_code_size !== head.size || m_status !== head.status) begin
                    if (fault_count < REPORT_LIMIT)
                        $display("%0t: expected sym %0d code %h size %0d status %0d, got %s",
                                 $time, head.sym, head.code, head.size, head.status,
                                 $sformatf("sym %0d code %h size %0d status %0d",
                                           m_out_symbol, m_code_bits, m_code_size,
                                           m_status));
                    fault_count++;
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t dir_rows [$];
        bit       held, paused, saturated;
        held      = 1'b0;
        paused    = 1'b0;
        saturated = 1'b0;

        // Directed cases: empty lookups, counts with no codes, ignored words,
        // skipped lengths, overrun, early last mark and overfull counts.
        dir_rows.push_back(dir_row(KIND_LOOKUP, 0, 0, 0, 0, 1, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_LOOKUP, 31, 255, 255, 1, 1, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_SYMBOL, 0, 0, 7, 0, 1, 0, 0, STATUS_OVERFLOW));
        dir_rows.push_back(dir_row(KIND_COUNT, 0, 255, 0, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_COUNT, 31, 255, 0, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_COUNT, 17, 1, 0, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_SYMBOL, 0, 0, 9, 1, 1, 0, 0, STATUS_OVERFLOW));
        dir_rows.push_back(dir_row(KIND_UNUSED, 5, 3, 3, 1, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_COUNT, 1, 1, 0, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_COUNT, 2, 1, 0, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_COUNT, 16, 2, 0, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_SYMBOL, 0, 0, 0, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_SYMBOL, 0, 0, 255, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_SYMBOL, 0, 0, 128, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_SYMBOL, 0, 0, 200, 1, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_SYMBOL, 0, 0, 1, 0, 1, 0, 0, STATUS_OVERFLOW));
        dir_rows.push_back(dir_row(KIND_LOOKUP, 0, 0, 0, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_LOOKUP, 0, 0, 128, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_LOOKUP, 0, 0, 1, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_COUNT, 8, 255, 0, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_SYMBOL, 0, 0, 42, 1, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_SYMBOL, 0, 0, 43, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_LOOKUP, 0, 0, 42, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_COUNT, 1, 255, 0, 0, 0, 0, 0, STATUS_OK));
        dir_rows.push_back(dir_row(KIND_SYMBOL, 0, 0, 5, 0, 0, 0, 0, STATUS_OK));

        // Reset is held low from the start and released on a falling edge.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) offer_word(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

        // Random tables, with one saturating run, one long hold-off and one drain pause.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (!held && items_sent >= 500) begin
                held         = 1'b1;
                hold_off_req = 1'b1;
            end
            if (!paused && items_sent >= 1000) begin
                paused = 1'b1;
                @(negedge aclk);
                s_valid <= 1'b0;
                while (expected_codes.size() != 0) @(posedge aclk);
            end
            if (!saturated && items_sent >= 200) begin
                saturated = 1'b1;
                send_random_table(1'b1);
            end else begin
                send_random_table(1'b0);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
